FILE: sv/i2cms_pkg.sv
// Package for the I2C master byte sequencer: command codes, phase encoding,
// configuration register indexes and the item and result structures.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

  // Field widths of the channels, the bit counter and the configuration port
  localparam int CMD_W   = 3;
  localparam int ADDR_W  = 7;
  localparam int BYTE_W  = 8;
  localparam int TICK_W  = 16;
  localparam int CNT_W   = 4;
  localparam int CFG_IDX_W = 1;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_STOP  = 3'd4
  } cmd_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_TICKS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TICKS = 1'b1;

  // Reset values of the timing registers
  localparam logic [TICK_W-1:0] LOW_TICKS_RST  = 16'd5;
  localparam logic [TICK_W-1:0] HIGH_TICKS_RST = 16'd4;

  // Byte constants: released bus, ACK answer and bits per byte
  localparam logic [BYTE_W-1:0] BYTE_RELEASED = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_ACK      = 8'h7F;
  localparam logic [CNT_W-1:0]  BITS_PER_BYTE = 4'd8;

  // Sequencer phases; bit phases are base + 3 * kind + sub
  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_ST_SCL     = 5'd1,
    PH_ST_SDA     = 5'd2,
    PH_ST_SETUP   = 5'd3,
    PH_ST_HOLD    = 5'd4,
    PH_SP_SCL     = 5'd5,
    PH_SP_SETUP   = 5'd6,
    PH_SP_HOLD    = 5'd7,
    PH_OUT8_RISE  = 5'd8,
    PH_OUT8_HIGH  = 5'd9,
    PH_OUT8_LOW   = 5'd10,
    PH_ACKIN_RISE = 5'd11,
    PH_ACKIN_HIGH = 5'd12,
    PH_ACKIN_LOW  = 5'd13,
    PH_IN8_RISE   = 5'd14,
    PH_IN8_HIGH   = 5'd15,
    PH_IN8_LOW    = 5'd16,
    PH_ACKOUT_RISE = 5'd17,
    PH_ACKOUT_HIGH = 5'd18,
    PH_ACKOUT_LOW  = 5'd19
  } phase_t;

  // Kind of bit group and sub-phase within one SCL period
  typedef enum logic [1:0] {
    KIND_OUT8   = 2'd0,
    KIND_ACKIN  = 2'd1,
    KIND_IN8    = 2'd2,
    KIND_ACKOUT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SUB_RISE = 2'd0,
    SUB_HIGH = 2'd1,
    SUB_LOW  = 2'd2
  } sub_t;

  // One input transfer
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] slave_addr;
    logic              read_dir;
    logic [BYTE_W-1:0] wr_byte;
    logic              last_read;
    logic              scl_level;
    logic              sda_level;
  } item_t;

  // One result transfer
  typedef struct packed {
    logic              scl_pull;
    logic              sda_pull;
    logic              busy_res;
    logic              done_res;
    logic              nack;
    logic [BYTE_W-1:0] read_data;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/i2cms_if.sv
// Valid/ready channel interfaces for the I2C master byte sequencer.
// Depends on i2cms_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface i2cms_in_if;
  import i2cms_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ADDR_W-1:0] slave_addr;
  logic              read_dir;
  logic [BYTE_W-1:0] wr_byte;
  logic              last_read;
  logic              scl_level;
  logic              sda_level;

  modport source (
    output valid, cmd, slave_addr, read_dir, wr_byte, last_read, scl_level, sda_level,
    input  ready
  );
  modport sink (
    input  valid, cmd, slave_addr, read_dir, wr_byte, last_read, scl_level, sda_level,
    output ready
  );
endinterface

interface i2cms_out_if;
  import i2cms_pkg::*;

  logic              valid;
  logic              ready;
  logic              scl_pull;
  logic              sda_pull;
  logic              busy_res;
  logic              done_res;
  logic              nack;
  logic [BYTE_W-1:0] read_data;

  modport source (
    output valid, scl_pull, sda_pull, busy_res, done_res, nack, read_data,
    input  ready
  );
  modport sink (
    input  valid, scl_pull, sda_pull, busy_res, done_res, nack, read_data,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/i2c_master_byte_sequencer.sv
// I2C master byte sequencer, one timing tick per input transfer.
// Depends on i2cms_pkg and the channel interfaces in i2cms_if.sv.
//
// Use: each input transfer on in_ch is one tick of the bus timing, carrying
// a command (tick only, start, write byte, read byte, stop), its operands and
// the sampled SCL and SDA levels. Each tick yields exactly one result on
// out_ch: the SCL and SDA pull-downs to apply, busy, a done pulse, the
// nack flag and the last byte read. Commands arriving while busy are ignored.
// SCL low and high periods come from low_ticks and high_ticks, written on
// the cfg_ port while no tick is outstanding; a value of zero acts as one.
// A tick is first held in the input register; its result is then registered
// in the result register, from which it is valid on out_ch. Throughput: one
// tick per cycle while out_ch is ready; the whole state update is a single
// pass of logic between the two registers.
// Reset: the sequencer returns to idle with both lines released and the
// timing registers at five low and four high ticks.
// Stalls: when out_ch is not ready the result register holds and the input
// register absorbs one more tick; in_ch.ready falls only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_sequencer (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  i2cms_in_if.sink                                in_ch,
  i2cms_out_if.source                             out_ch,
  input  wire logic                               cfg_wr_en,
  input  wire logic [i2cms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [i2cms_pkg::TICK_W-1:0]       cfg_wdata
);
  import i2cms_pkg::*;

  // Bit phase encoding helpers
  function automatic phase_t bit_phase(kind_t k, sub_t s);
    return phase_t'(5'(PH_OUT8_RISE) + 5'(k) * 5'd3 + 5'(s));
  endfunction

  function automatic kind_t phase_kind(phase_t p);
    kind_t k;
    case (p)
      PH_ACKIN_RISE, PH_ACKIN_HIGH, PH_ACKIN_LOW:    k = KIND_ACKIN;
      PH_IN8_RISE, PH_IN8_HIGH, PH_IN8_LOW:          k = KIND_IN8;
      PH_ACKOUT_RISE, PH_ACKOUT_HIGH, PH_ACKOUT_LOW: k = KIND_ACKOUT;
      default:                                       k = KIND_OUT8;
    endcase
    return k;
  endfunction

  // Input register
  logic    in_valid_r, in_valid_nxt;
  item_t   item_r;
  logic    advance;

  // Result register
  logic    out_valid_r, out_valid_nxt;
  result_t res_r, res_nxt;

  // Sequencer state
  phase_t             phase_r, phase_nxt;
  logic [BYTE_W-1:0]  shift_r, shift_nxt;
  logic [CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [TICK_W-1:0]  timer_r, timer_nxt;
  logic               scl_drv_r, scl_drv_nxt;
  logic               sda_drv_r, sda_drv_nxt;
  logic               nack_r, nack_nxt;
  logic [BYTE_W-1:0]  rx_r, rx_nxt;
  logic               final_r, final_nxt;
  logic               done_nxt;

  // Timing registers
  logic [TICK_W-1:0]  low_ticks_r, high_ticks_r;

  // Helper values of the current tick
  logic               expired;
  logic [TICK_W-1:0]  timer_after;
  logic [BYTE_W-1:0]  shift_in;
  logic [CNT_W-1:0]   cnt_dec;
  kind_t              kind_cur, kind_new;

  // Handshakes: a tick moves to the result register whenever it is free
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || !out_valid_r || out_ch.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_ch.valid && in_ch.ready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the tick payload on an input transfer
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.cmd        <= in_ch.cmd;
      item_r.slave_addr <= in_ch.slave_addr;
      item_r.read_dir   <= in_ch.read_dir;
      item_r.wr_byte    <= in_ch.wr_byte;
      item_r.last_read  <= in_ch.last_read;
      item_r.scl_level  <= in_ch.scl_level;
      item_r.sda_level  <= in_ch.sda_level;
    end
  end

  // Timing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_ticks_r  <= LOW_TICKS_RST;
      high_ticks_r <= HIGH_TICKS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LOW_TICKS:  low_ticks_r  <= cfg_wdata;
        CFG_HIGH_TICKS: high_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Shared timer, shift and counter steps
  assign expired     = (timer_r <= TICK_W'(1));
  assign timer_after = expired ? '0 : timer_r - TICK_W'(1);
  assign shift_in    = {shift_r[BYTE_W-2:0], item_r.sda_level};
  assign cnt_dec     = (bit_cnt_r != '0) ? bit_cnt_r - CNT_W'(1) : bit_cnt_r;
  assign kind_cur    = phase_kind(phase_r);

  // Next state of the sequencer for the tick in the input register
  always_comb begin
    phase_nxt   = phase_r;
    shift_nxt   = shift_r;
    bit_cnt_nxt = bit_cnt_r;
    timer_nxt   = timer_r;
    scl_drv_nxt = scl_drv_r;
    sda_drv_nxt = sda_drv_r;
    nack_nxt    = nack_r;
    rx_nxt      = rx_r;
    final_nxt   = final_r;
    done_nxt    = 1'b0;
    kind_new    = kind_cur;

    case (phase_r)
      PH_IDLE: begin
        case (item_r.cmd)
          CMD_START: begin
            shift_nxt   = {item_r.slave_addr, item_r.read_dir};
            scl_drv_nxt = 1'b0;
            phase_nxt   = PH_ST_SCL;
          end
          CMD_WRITE: begin
            scl_drv_nxt = 1'b1;
            shift_nxt   = item_r.wr_byte;
            sda_drv_nxt = ~item_r.wr_byte[BYTE_W-1];
            bit_cnt_nxt = BITS_PER_BYTE;
            timer_nxt   = low_ticks_r;
            phase_nxt   = PH_OUT8_LOW;
          end
          CMD_READ: begin
            final_nxt   = item_r.last_read;
            scl_drv_nxt = 1'b1;
            shift_nxt   = BYTE_RELEASED;
            sda_drv_nxt = 1'b0;
            bit_cnt_nxt = BITS_PER_BYTE;
            timer_nxt   = low_ticks_r;
            phase_nxt   = PH_IN8_LOW;
          end
          CMD_STOP: begin
            sda_drv_nxt = 1'b1;
            scl_drv_nxt = 1'b0;
            phase_nxt   = PH_SP_SCL;
          end
          default: ;
        endcase
      end

      // START: wait for SCL and SDA high, pull SDA, then pull SCL
      PH_ST_SCL: begin
        if (item_r.scl_level) begin
          sda_drv_nxt = 1'b0;
          phase_nxt   = PH_ST_SDA;
        end
      end
      PH_ST_SDA: begin
        if (item_r.sda_level) begin
          sda_drv_nxt = 1'b1;
          timer_nxt   = low_ticks_r;
          phase_nxt   = PH_ST_SETUP;
        end
      end
      PH_ST_SETUP: begin
        timer_nxt = timer_after;
        if (expired) begin
          scl_drv_nxt = 1'b1;
          timer_nxt   = high_ticks_r;
          phase_nxt   = PH_ST_HOLD;
        end
      end
      PH_ST_HOLD: begin
        timer_nxt = timer_after;
        if (expired) begin
          scl_drv_nxt = 1'b1;
          sda_drv_nxt = ~shift_r[BYTE_W-1];
          bit_cnt_nxt = BITS_PER_BYTE;
          timer_nxt   = low_ticks_r;
          phase_nxt   = PH_OUT8_LOW;
        end
      end

      // STOP: release SCL, wait, then release SDA and hold
      PH_SP_SCL: begin
        if (item_r.scl_level) begin
          timer_nxt = low_ticks_r;
          phase_nxt = PH_SP_SETUP;
        end
      end
      PH_SP_SETUP: begin
        timer_nxt = timer_after;
        if (expired) begin
          sda_drv_nxt = 1'b0;
          timer_nxt   = high_ticks_r;
          phase_nxt   = PH_SP_HOLD;
        end
      end
      PH_SP_HOLD: begin
        timer_nxt = timer_after;
        if (expired) begin
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end
      end

      // Rising edge: release SCL and wait while a slave stretches it
      PH_OUT8_RISE, PH_ACKIN_RISE, PH_IN8_RISE, PH_ACKOUT_RISE: begin
        scl_drv_nxt = 1'b0;
        if (item_r.scl_level) begin
          timer_nxt = high_ticks_r;
          phase_nxt = bit_phase(kind_cur, SUB_HIGH);
        end
      end

      // High period ends: sample SDA, pull SCL and set up the next bit
      PH_OUT8_HIGH, PH_ACKIN_HIGH, PH_IN8_HIGH, PH_ACKOUT_HIGH: begin
        timer_nxt = timer_after;
        if (expired) begin
          shift_nxt   = shift_in;
          bit_cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            case (kind_cur)
              KIND_OUT8: begin
                shift_nxt   = BYTE_RELEASED;
                bit_cnt_nxt = CNT_W'(1);
                kind_new    = KIND_ACKIN;
              end
              KIND_ACKIN: begin
                nack_nxt  = shift_in[0];
                shift_nxt = BYTE_RELEASED;
              end
              KIND_IN8: begin
                rx_nxt      = shift_in;
                shift_nxt   = final_r ? BYTE_RELEASED : BYTE_ACK;
                bit_cnt_nxt = CNT_W'(1);
                kind_new    = KIND_ACKOUT;
              end
              default: begin
                shift_nxt = BYTE_RELEASED;
              end
            endcase
          end
          sda_drv_nxt = ~shift_nxt[BYTE_W-1];
          scl_drv_nxt = 1'b1;
          timer_nxt   = low_ticks_r;
          phase_nxt   = bit_phase(kind_new, SUB_LOW);
        end
      end

      // Low period ends: finish the command or release SCL for the next bit
      PH_OUT8_LOW, PH_ACKIN_LOW, PH_IN8_LOW, PH_ACKOUT_LOW: begin
        timer_nxt = timer_after;
        if (expired) begin
          if (bit_cnt_r == '0) begin
            phase_nxt = PH_IDLE;
            done_nxt  = 1'b1;
          end else begin
            scl_drv_nxt = 1'b0;
            phase_nxt   = bit_phase(kind_cur, SUB_RISE);
          end
        end
      end

      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Result of the tick, taken from the state after it
  always_comb begin
    res_nxt.scl_pull  = scl_drv_nxt;
    res_nxt.sda_pull  = sda_drv_nxt;
    res_nxt.busy_res  = (phase_nxt != PH_IDLE);
    res_nxt.done_res  = done_nxt;
    res_nxt.nack      = nack_nxt;
    res_nxt.read_data = rx_nxt;
  end

  // State update, one tick per cycle while ticks advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      shift_r   <= BYTE_RELEASED;
      bit_cnt_r <= '0;
      timer_r   <= '0;
      scl_drv_r <= 1'b0;
      sda_drv_r <= 1'b0;
      nack_r    <= 1'b0;
      rx_r      <= '0;
      final_r   <= 1'b0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      shift_r   <= shift_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      timer_r   <= timer_nxt;
      scl_drv_r <= scl_drv_nxt;
      sda_drv_r <= sda_drv_nxt;
      nack_r    <= nack_nxt;
      rx_r      <= rx_nxt;
      final_r   <= final_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  // Result channel
  assign out_ch.valid     = out_valid_r;
  assign out_ch.scl_pull  = res_r.scl_pull;
  assign out_ch.sda_pull  = res_r.sda_pull;
  assign out_ch.busy_res  = res_r.busy_res;
  assign out_ch.done_res  = res_r.done_res;
  assign out_ch.nack      = res_r.nack;
  assign out_ch.read_data = res_r.read_data;

endmodule

`default_nettype wire

FILE: sv/i2cms_checker.sv
// Port-level checks for the I2C master byte sequencer, bound to the top level.
// Depends on i2cms_pkg for widths and on i2c_master_byte_sequencer's ports.
`timescale 1ns / 1ps
`default_nettype none

module i2cms_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          scl_pull,
  input wire logic                          sda_pull,
  input wire logic                          busy_res,
  input wire logic                          done_res,
  input wire logic                          nack,
  input wire logic [i2cms_pkg::BYTE_W-1:0]  read_data
);
  import i2cms_pkg::*;

  logic out_xfer;
  logic last_done_r;

  assign out_xfer = out_valid && out_ready;

  // Done flag of the most recent result transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_done_r <= 1'b0;
    end else if (out_xfer) begin
      last_done_r <= done_res;
    end
  end

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(scl_pull) && $stable(sda_pull)
      && $stable(busy_res) && $stable(done_res) && $stable(nack) && $stable(read_data))
    else $error("result changed while stalled");

  // A completing command leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  // Whenever idle, SDA is released
  a_idle_sda: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy_res |-> !sda_pull)
    else $error("SDA pulled while idle");

  // No command completes on the tick right after another completes
  a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && last_done_r |-> !done_res)
    else $error("done on two consecutive results");

endmodule

bind i2c_master_byte_sequencer i2cms_checker u_i2cms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .scl_pull  (out_ch.scl_pull),
  .sda_pull  (out_ch.sda_pull),
  .busy_res  (out_ch.busy_res),
  .done_res  (out_ch.done_res),
  .nack      (out_ch.nack),
  .read_data (out_ch.read_data)
);

`default_nettype wire
